### rtl/page_bitmap_allocator_assert.svh
// assertion macros for the page bitmap allocator
// depends on nothing; included by the top level
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
// implication checked every clock outside reset
`define PBA_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### rtl/pba_pkg.sv
// shared types and constants of the page bitmap allocator
// no dependencies
package pba_pkg;
  localparam int MapWords = 1024;
  localparam int WordBits = 32;
  localparam int WordAw = $clog2(MapWords);
  localparam int TotalPages = MapWords * WordBits;
  localparam int PageW = 15;
  localparam int CntW = 16;
  localparam int PosW = 17;

  localparam logic [2:0] FUNC_ALLOC_PAGE = 3'd0;
  localparam logic [2:0] FUNC_RANGE_DMA = 3'd1;
  localparam logic [2:0] FUNC_RANGE_HIGH = 3'd2;
  localparam logic [2:0] FUNC_FREE = 3'd3;
  localparam logic [2:0] FUNC_MARK = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_PAST = 2'd3;

  typedef enum logic [2:0] {
    OP_SEARCH = 3'd0,
    OP_WRITE = 3'd1,
    OP_REPORT = 3'd2
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t op;
    logic [1:0] status;
    logic make_free;
    logic dma_check;
    logic [PosW-1:0] start;
    logic [PosW-1:0] count;
    logic [PosW-1:0] limit;
  } cmd_t;
endpackage

### rtl/pba_front.sv
// front end: accepts requests, classifies them and pushes commands
// depends on pba_pkg
module pba_front (
  input  logic valid,
  output logic ready,
  input  logic [2:0] func,
  input  logic [14:0] page_index,
  input  logic [15:0] page_count,
  input  logic [15:0] boundary,
  output logic q_push,
  output pba_pkg::cmd_t q_data,
  input  logic q_full
);
  logic [pba_pkg::PosW-1:0] idx_w, cnt_w, bnd_w, lo;

  assign ready = !q_full;
  assign q_push = valid && !q_full;
  assign idx_w = {2'b0, page_index};
  assign cnt_w = {1'b0, page_count};
  assign bnd_w = {1'b0, boundary};
  assign lo = (idx_w > bnd_w) ? idx_w : bnd_w;

  always_comb begin
    q_data = '0;
    q_data.op = pba_pkg::OP_REPORT;
    q_data.status = pba_pkg::ST_OK;
    q_data.limit = bnd_w;
    unique case (func) inside
      pba_pkg::FUNC_ALLOC_PAGE: begin
        q_data.op = pba_pkg::OP_SEARCH;
        q_data.start = lo;
        q_data.count = 17'd1;
      end
      pba_pkg::FUNC_RANGE_DMA, pba_pkg::FUNC_RANGE_HIGH: begin
        if (page_count == '0) begin
          q_data.status = pba_pkg::ST_ZERO;
        end else begin
          q_data.op = pba_pkg::OP_SEARCH;
          q_data.start = (func == pba_pkg::FUNC_RANGE_DMA) ? '0 : bnd_w;
          q_data.count = cnt_w;
          q_data.dma_check = (func == pba_pkg::FUNC_RANGE_DMA);
        end
      end
      pba_pkg::FUNC_FREE, pba_pkg::FUNC_MARK: begin
        if (page_count == '0) begin
          q_data.status = pba_pkg::ST_ZERO;
        end else if (idx_w + cnt_w > pba_pkg::PosW'(pba_pkg::TotalPages)) begin
          q_data.status = pba_pkg::ST_PAST;
        end else begin
          q_data.op = pba_pkg::OP_WRITE;
          q_data.start = idx_w;
          q_data.count = cnt_w;
          q_data.make_free = (func == pba_pkg::FUNC_FREE);
        end
      end
      default: begin
      end
    endcase
  end
endmodule

### rtl/pba_queue.sv
// two-entry command queue between front and back
// depends on pba_pkg
module pba_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pba_pkg::cmd_t push_data,
  output logic full,
  input  logic pop,
  output pba_pkg::cmd_t pop_data,
  output logic not_empty
);
  pba_pkg::cmd_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/pba_back.sv
// back end: bitmap memory, bit-serial search and range write
// depends on pba_pkg
module pba_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  pba_pkg::cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [14:0] result_page,
  output logic [1:0] status,
  output logic [15:0] free_count
);
  localparam int AW = pba_pkg::WordAw;
  localparam int PW = pba_pkg::PosW;
  localparam int BW = $clog2(pba_pkg::WordBits);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_SRD = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_WRD = 8'b0001_0000,
    S_WMOD = 8'b0010_0000,
    S_OUT = 8'b0100_0000,
    S_BIT = 8'b1000_0000
  } state_t;

  state_t state;
  logic [pba_pkg::WordBits-1:0] mem [pba_pkg::MapWords];
  logic [pba_pkg::WordBits-1:0] rdata;
  logic [AW-1:0] raddr, clr_addr;
  logic [PW-1:0] pos, run, run_start, wpos;
  logic [PW-1:0] free_total;
  pba_pkg::cmd_t c;
  logic [BW-1:0] bit_i;
  logic bit_free;
  logic found_mode;

  assign bit_free = rdata[bit_i];
  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign wpos = pos + 1'b1;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      free_total <= PW'(pba_pkg::TotalPages);
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          mem[clr_addr] <= '1;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(pba_pkg::MapWords - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c <= cmd;
            result_page <= '0;
            status <= cmd.status;
            run <= '0;
            found_mode <= 1'b0;
            pos <= cmd.start;
            raddr <= cmd.start[BW +: AW];
            unique case (cmd.op)
              pba_pkg::OP_SEARCH: begin
                if (cmd.start >= PW'(pba_pkg::TotalPages)) begin
                  status <= pba_pkg::ST_NOFREE;
                  state <= S_OUT;
                end else state <= S_SRD;
              end
              pba_pkg::OP_WRITE: state <= S_SRD;
              default: state <= S_OUT;
            endcase
          end
        end
        S_SRD: begin
          // read latency
          bit_i <= pos[BW-1:0];
          state <= S_BIT;
        end
        S_BIT: begin
          if (c.op == pba_pkg::OP_WRITE || found_mode) begin
            state <= S_WMOD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // scan one bit of the current word; each next bit is read anew from memory
          if (bit_free) begin
            if (run == '0) run_start <= pos;
            if (run + 1'b1 >= c.count) begin
              if (c.dma_check && ((run == '0 ? pos : run_start) >= c.limit)) begin
                status <= pba_pkg::ST_NOFREE;
                state <= S_OUT;
              end else begin
                result_page <= (run == '0) ? pos[14:0] : run_start[14:0];
                found_mode <= 1'b1;
                pos <= (run == '0) ? pos : run_start;
                raddr <= ((run == '0) ? pos[BW +: AW] : run_start[BW +: AW]);
                state <= S_WRD;
              end
            end else begin
              run <= run + 1'b1;
              state <= S_WRD;
              pos <= pos + 1'b1;
              raddr <= AW'((pos + 1'b1) >> BW);
            end
          end else begin
            run <= '0;
            pos <= pos + 1'b1;
            raddr <= AW'((pos + 1'b1) >> BW);
            state <= S_WRD;
          end
          if (!(bit_free && run + 1'b1 >= c.count) &&
              pos + 1'b1 >= PW'(pba_pkg::TotalPages)) begin
            status <= pba_pkg::ST_NOFREE;
            state <= S_OUT;
          end
        end
        S_WRD: begin
          bit_i <= pos[BW-1:0];
          state <= S_BIT;
          if (found_mode) begin
            c.make_free <= 1'b0;
            c.op <= pba_pkg::OP_WRITE;
            c.start <= pos;
            found_mode <= 1'b0;
          end
        end
        S_WMOD: begin
          // set or clear one bit, account if it changed
          if (c.op == pba_pkg::OP_WRITE) begin
            if (bit_free != c.make_free) begin
              free_total <= c.make_free ? free_total + 1'b1 : free_total - 1'b1;
            end
            mem[pos[BW +: AW]] <= c.make_free ? (rdata | (1 << bit_i))
                                              : (rdata & ~(1 << bit_i));
            if (wpos >= c.start + c.count) state <= S_OUT;
            else begin
              pos <= wpos;
              raddr <= AW'(wpos >> BW);
              state <= S_SRD;
            end
          end else state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            free_count <= free_total[15:0];
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/page_bitmap_allocator.sv
// top level of the page bitmap allocator
// depends on pba_pkg, pba_front, pba_queue, pba_back and the assert header
// A request is one transaction; each yields one response transaction, in
// order. After reset the bitmap is set to all free by a pass over all 1024
// words before the first request is served; up to two requests are still
// taken into the command queue meanwhile. Work is bit serial over the bitmap
// memory: a search steps through S_WRD, S_BIT and S_SCAN for each page
// examined and a range write through S_SRD, S_BIT and S_WMOD for each page
// marked. A request that only reports a status (count zero, range past end,
// limit past end, unused code) goes from S_IDLE straight to S_OUT without
// touching the bitmap; the longest request, a full-length range found on an
// empty map, scans and then marks every page. Write the dma boundary only
// while no request is in flight.
`include "page_bitmap_allocator_assert.svh"
module page_bitmap_allocator (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [2:0] func,
  input  logic [14:0] page_index,
  input  logic [15:0] page_count,
  output logic out_valid,
  input  logic out_ready,
  output logic [14:0] result_page,
  output logic [1:0] status,
  output logic [15:0] free_count,
  input  logic cfg_we,
  input  logic [15:0] cfg_data
);
  logic [15:0] boundary;
  logic q_push, q_full, q_pop, q_ne;
  pba_pkg::cmd_t q_in, q_out;

  // dma boundary register
  always_ff @(posedge clk) begin
    if (rst) boundary <= 16'd4096;
    else if (cfg_we) boundary <= cfg_data;
  end

  pba_front u_front (
    .valid, .ready, .func, .page_index, .page_count,
    .boundary, .q_push, .q_data(q_in), .q_full
  );

  pba_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .not_empty(q_ne)
  );

  pba_back u_back (
    .clk, .rst, .cmd_valid(q_ne), .cmd(q_out), .cmd_pop(q_pop),
    .out_valid, .out_ready, .result_page, .status, .free_count
  );

  `PBA_ASSERT_IMPL(a_no_push_full, q_full, !q_push, "push into full queue")
  `PBA_ASSERT_IMPL(a_pop_nonempty, q_pop, q_ne, "pop from empty queue")
  `PBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule

### dv/tb_page_bitmap_allocator.sv
// testbench for the page bitmap allocator: directed and random requests
// depends on pba_pkg and page_bitmap_allocator; predicts each response in-bench
`timescale 1ns / 1ps

module tb_page_bitmap_allocator;

  typedef struct {
    logic [2:0]  func;
    logic [14:0] idx;
    logic [15:0] cnt;
  } page_req_t;

  typedef struct {
    logic [14:0] page;
    logic [1:0]  stat;
    logic [15:0] free;
  } page_rsp_t;

  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [14:0] page_index;
  logic [15:0] page_count;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] result_page;
  logic [1:0]  status;
  logic [15:0] free_count;
  logic        cfg_we;
  logic [15:0] cfg_data;

  page_bitmap_allocator u_dut (
    .clk(clk), .rst(rst),
    .valid(valid), .ready(ready),
    .func(func), .page_index(page_index), .page_count(page_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_page(result_page), .status(status), .free_count(free_count),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor copy of the allocator state
  bit        free_map[pba_pkg::TotalPages];
  int        free_cnt;
  int        boundary;

  page_req_t pending_reqs[$];
  page_rsp_t expected_rsps[$];
  int        fail_count;
  int        rsp_seen;
  bit        sent;
  bit        gappy;
  int        stall_pct;
  int        burst_left;
  int        gap_left;
  int        hold_left;
  bit        hold_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // first free run of n pages at or above start
  function automatic bit find_free_run(int start, int n, output int first);
    int run;
    int s;
    run = 0;
    s = 0;
    first = 0;
    for (int p = start; p < pba_pkg::TotalPages; p++) begin
      if (free_map[p]) begin
        if (run == 0) s = p;
        run++;
        if (run >= n) begin
          first = s;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  // flip one page, keeping the free count in step
  function automatic void set_page(int p, bit make_free);
    if (free_map[p] != make_free) begin
      free_map[p] = make_free;
      free_cnt += make_free ? 1 : -1;
    end
  endfunction

  function automatic page_rsp_t allocate_or_release(page_req_t r);
    page_rsp_t o;
    int p;
    int s;
    int idx;
    int cnt;
    idx = int'(r.idx);
    cnt = int'(r.cnt);
    o.page = '0;
    o.stat = pba_pkg::ST_OK;
    case (r.func) inside
      pba_pkg::FUNC_ALLOC_PAGE: begin
        o.stat = pba_pkg::ST_NOFREE;
        for (p = (idx > boundary) ? idx : boundary; p < pba_pkg::TotalPages; p++) begin
          if (free_map[p]) begin
            set_page(p, 1'b0);
            o.page = p[14:0];
            o.stat = pba_pkg::ST_OK;
            break;
          end
        end
      end
      pba_pkg::FUNC_RANGE_DMA, pba_pkg::FUNC_RANGE_HIGH: begin
        if (cnt == 0) begin
          o.stat = pba_pkg::ST_ZERO;
        end else if (find_free_run((r.func == pba_pkg::FUNC_RANGE_DMA) ? 0 : boundary,
                                   cnt, s) &&
                     (r.func == pba_pkg::FUNC_RANGE_HIGH || s < boundary)) begin
          for (int k = 0; k < cnt; k++) set_page(s + k, 1'b0);
          o.page = s[14:0];
        end else begin
          o.stat = pba_pkg::ST_NOFREE;
        end
      end
      pba_pkg::FUNC_FREE, pba_pkg::FUNC_MARK: begin
        if (cnt == 0) o.stat = pba_pkg::ST_ZERO;
        else if (idx + cnt > pba_pkg::TotalPages) o.stat = pba_pkg::ST_PAST;
        else for (int k = 0; k < cnt; k++) set_page(idx + k, r.func == pba_pkg::FUNC_FREE);
      end
      default: ;
    endcase
    o.free = free_cnt[15:0];
    return o;
  endfunction

  function automatic page_req_t mk_req(logic [2:0] f, int idx, int cnt);
    page_req_t r;
    r.func = f;
    r.idx = idx[14:0];
    r.cnt = cnt[15:0];
    return r;
  endfunction

  // random request, mostly small ranges kept near page 0 and the boundary
  function automatic page_req_t random_req();
    int r;
    int base;
    r = $urandom_range(0, 99);
    base = ($urandom_range(0, 1) == 0 || boundary > 30000) ? 0 : boundary;
    if (r < 25) begin
      if ($urandom_range(0, 9) == 0) return mk_req(pba_pkg::FUNC_ALLOC_PAGE, $urandom, $urandom);
      return mk_req(pba_pkg::FUNC_ALLOC_PAGE, base + $urandom_range(0, 1023), $urandom);
    end
    if (r < 40) return mk_req(pba_pkg::FUNC_RANGE_DMA, $urandom, $urandom_range(1, 6));
    if (r < 55) return mk_req(pba_pkg::FUNC_RANGE_HIGH, $urandom, $urandom_range(1, 6));
    if (r < 80) return mk_req(pba_pkg::FUNC_FREE, base + $urandom_range(0, 2047),
                              $urandom_range(1, 64));
    if (r < 90) return mk_req(pba_pkg::FUNC_MARK, base + $urandom_range(0, 2047),
                              $urandom_range(1, 16));
    if (r < 94) return mk_req(3'($urandom_range(1, 4)), $urandom, 0);
    // range past end: index at least half, count at least the whole map
    if (r < 97) return mk_req(3'($urandom_range(3, 4)), $urandom | 32'h4000, $urandom | 32'h8000);
    return mk_req(3'($urandom_range(5, 7)), $urandom, $urandom);
  endfunction

  // sender: bursts of transactions, separated by random gaps in gappy phases
  always @(negedge clk) begin
    if (!rst && (!valid || sent)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        page_req_t r;
        r = pending_reqs.pop_front();
        valid <= 1'b1;
        func <= r.func;
        page_index <= r.idx;
        page_count <= r.cnt;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          if (gappy) gap_left <= $urandom_range(1, 15);
        end
      end else begin
        valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the input backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && rsp_seen == 30) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // accept requests into the predictor, then check responses in order
  always @(posedge clk) begin
    page_req_t r;
    page_rsp_t e;
    sent = 1'b0;
    if (!rst && valid && ready) begin
      sent = 1'b1;
      r.func = func;
      r.idx = page_index;
      r.cnt = page_count;
      expected_rsps.push_back(allocate_or_release(r));
    end
    if (!rst && out_valid && out_ready) begin
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        e = expected_rsps.pop_front();
        if (result_page !== e.page) begin
          $error("result_page expected %0d actual %0d", e.page, result_page);
          fail_count++;
        end
        if (status !== e.stat) begin
          $error("status expected %0d actual %0d", e.stat, status);
          fail_count++;
        end
        if (free_count !== e.free) begin
          $error("free_count expected %0d actual %0d", e.free, free_count);
          fail_count++;
        end
      end
    end
  end

  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() > 0 || valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_boundary(int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    boundary = v;
  endtask

  int boundary_list[7] = '{4096, 0, 100, 32768, 4133, 32767, 4096};

  initial begin
    rst = 1'b1;
    valid = 1'b0;
    func = '0;
    page_index = '0;
    page_count = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    rsp_seen = 0;
    sent = 1'b0;
    gappy = 1'b0;
    stall_pct = 0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    foreach (free_map[i]) free_map[i] = 1'b1;
    free_cnt = pba_pkg::TotalPages;
    boundary = 4096;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every function, error statuses
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_ALLOC_PAGE, 0, 0));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_ALLOC_PAGE, 32767, 16'hffff));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_ALLOC_PAGE, 5000, 7));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_DMA, 32767, 1));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_DMA, 0, 0));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_DMA, 0, 5));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_HIGH, 0, 3));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_HIGH, 0, 0));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_FREE, 10, 0));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_FREE, 32767, 2));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_MARK, 1, 16'hffff));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_MARK, 32767, 1));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_FREE, 32767, 1));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_FREE, 20000, 4));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_MARK, 2, 1));
    pending_reqs.push_back(mk_req(3'd5, 32767, 16'hffff));
    pending_reqs.push_back(mk_req(3'd6, 1, 1));
    pending_reqs.push_back(mk_req(3'd7, 0, 0));
    // whole map used: allocation fails, run longer than what is left
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_MARK, 0, 32768));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_ALLOC_PAGE, 0, 0));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_DMA, 0, 32768));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_HIGH, 0, 1));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_FREE, 0, 32768));
    pending_reqs.push_back(mk_req(pba_pkg::FUNC_RANGE_DMA, 0, 2));
    drain();

    // random phases, each under its own boundary and idling pattern
    foreach (boundary_list[ph]) begin
      write_boundary(boundary_list[ph]);
      gappy = (ph % 2 == 1);
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
      repeat (80) pending_reqs.push_back(random_req());
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

### page_bitmap_allocator.f
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_front.sv
rtl/pba_queue.sv
rtl/pba_back.sv
rtl/page_bitmap_allocator.sv
dv/tb_page_bitmap_allocator.sv
